// File: rtl/core/r2d_pkg.sv
// ----------------------------------------------------------------------------
// r2d_pkg
// Shared types and constants of the ragged-to-dense copy/fill range core.
// ----------------------------------------------------------------------------
package r2d_pkg;

    // Deepest nesting the core tracks, and number of size registers.
    localparam int MAX_DIMS   = 4;
    localparam int REG_DIMS   = 4;
    localparam int DIM_LIMIT  = (MAX_DIMS < REG_DIMS) ? MAX_DIMS : REG_DIMS;
    localparam int DEPTH_W    = $clog2(MAX_DIMS + 1);
    localparam int SIZE_IDX_W = $clog2(REG_DIMS);

    // Field widths.
    localparam int COUNT_W  = 16;
    localparam int OFFSET_W = 32;
    localparam int ADDR_W   = 5;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Token kinds on the input stream. Code 3 carries no meaning.
    typedef enum logic [1:0] {
        TOK_BEGIN  = 2'd0,
        TOK_FINISH = 2'd1,
        TOK_COUNT  = 2'd2
    } token_kind_t;

    // Register indexes (word address bits).
    typedef enum logic [2:0] {
        REG_DIM_COUNT  = 3'd0,
        REG_DIM_SIZE0  = 3'd1,
        REG_DIM_SIZE1  = 3'd2,
        REG_DIM_SIZE2  = 3'd3,
        REG_DIM_SIZE3  = 3'd4
    } reg_index_t;

    // Configuration view handed to the front.
    typedef struct packed {
        logic                                 busy;
        logic [DEPTH_W-1:0]                   eff_dims;
        logic [REG_DIMS-1:0][COUNT_W-1:0]     dim_len;
        logic [MAX_DIMS:1][OFFSET_W-1:0]      stride;
    } r2d_cfg_t;

    // One classified operation travelling from the front to the back.
    typedef struct packed {
        logic                clr;
        logic                emit;
        logic                act;
        logic                inner;
        logic                over;
        logic                under;
        logic [COUNT_W-1:0]  count;
        logic [COUNT_W-1:0]  length;
        logic [COUNT_W-1:0]  shortfall;
        logic [OFFSET_W-1:0] stride;
    } r2d_op_t;

endpackage

// File: rtl/core/r2d_cfg.sv
// ----------------------------------------------------------------------------
// r2d_cfg
// Register file on the APB port and the stride sequencer that rebuilds the
// per-level strides after every write to a defined register.
// ----------------------------------------------------------------------------
module r2d_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [r2d_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output r2d_pkg::r2d_cfg_t            cfg
);
    import r2d_pkg::*;

    logic [2:0]                       dim_count_reg;
    logic [REG_DIMS-1:0][COUNT_W-1:0] dim_len_reg;
    logic [MAX_DIMS:1][OFFSET_W-1:0]  stride_reg;
    logic                             busy_reg;
    logic                             busy_next;
    logic [DEPTH_W-1:0]               step_reg;
    logic [DEPTH_W-1:0]               step_next;
    logic [DEPTH_W-1:0]               eff_dims;
    logic [DEPTH_W-1:0]               step_up;
    logic [SIZE_IDX_W-1:0]            size_idx;
    logic [COUNT_W+OFFSET_W-1:0]      prod;
    reg_index_t                       reg_idx;
    logic                             wr_en;
    logic                             wr_hit;

    assign pready  = 1'b1;
    assign reg_idx = reg_index_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // A write to a defined register restarts the stride sequencer.
    always_comb begin
        unique case (reg_idx)
            REG_DIM_COUNT, REG_DIM_SIZE0, REG_DIM_SIZE1,
            REG_DIM_SIZE2, REG_DIM_SIZE3: wr_hit = wr_en;
            default:                      wr_hit = 1'b0;
        endcase
    end

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_count_reg <= 3'd1;
            dim_len_reg   <= {REG_DIMS{16'd1}};
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DIM_COUNT: dim_count_reg  <= pwdata[2:0];
                REG_DIM_SIZE0: dim_len_reg[0] <= pwdata[COUNT_W-1:0];
                REG_DIM_SIZE1: dim_len_reg[1] <= pwdata[COUNT_W-1:0];
                REG_DIM_SIZE2: dim_len_reg[2] <= pwdata[COUNT_W-1:0];
                REG_DIM_SIZE3: dim_len_reg[3] <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (reg_idx)
            REG_DIM_COUNT: prdata = {29'd0, dim_count_reg};
            REG_DIM_SIZE0: prdata = {16'd0, dim_len_reg[0]};
            REG_DIM_SIZE1: prdata = {16'd0, dim_len_reg[1]};
            REG_DIM_SIZE2: prdata = {16'd0, dim_len_reg[2]};
            REG_DIM_SIZE3: prdata = {16'd0, dim_len_reg[3]};
            default:       prdata = 32'd0;
        endcase
    end

    // Effective dimension count: zero acts as one, large values clamp.
    always_comb begin
        if (dim_count_reg == 3'd0) begin
            eff_dims = DEPTH_W'(1);
        end else if (DEPTH_W'(dim_count_reg) > DEPTH_W'(DIM_LIMIT)) begin
            eff_dims = DEPTH_W'(DIM_LIMIT);
        end else begin
            eff_dims = DEPTH_W'(dim_count_reg);
        end
    end

    // One stride per cycle, from the innermost level outward.
    assign step_up  = step_reg + DEPTH_W'(1);
    assign size_idx = step_reg[SIZE_IDX_W-1:0];
    assign prod     = dim_len_reg[size_idx] * stride_reg[step_up];

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (wr_hit) begin
            busy_next = 1'b1;
            step_next = DEPTH_W'(MAX_DIMS - 1);
        end else if (busy_reg) begin
            if (step_reg == DEPTH_W'(1)) begin
                busy_next = 1'b0;
            end else begin
                step_next = step_reg - DEPTH_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= DEPTH_W'(MAX_DIMS - 1);
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_reg <= {MAX_DIMS{32'd1}};
        end else if (busy_reg && !wr_hit) begin
            if (step_reg >= eff_dims) begin
                stride_reg[step_reg] <= 32'd1;
            end else begin
                stride_reg[step_reg] <= prod[OFFSET_W-1:0];
            end
        end
    end

    assign cfg.busy     = busy_reg;
    assign cfg.eff_dims = eff_dims;
    assign cfg.dim_len  = dim_len_reg;
    assign cfg.stride   = stride_reg;

endmodule

// File: rtl/core/r2d_front.sv
// ----------------------------------------------------------------------------
// r2d_front
// Accepts nesting tokens, tracks depth and per-level counts, and classifies
// each finish token and each record start into an operation for the back.
// ----------------------------------------------------------------------------
module r2d_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] element_total
    input  logic [2:0]           s_tuser,   // [1:0] token_kind, [2] record_start
    input  r2d_pkg::r2d_cfg_t    cfg,
    input  logic                 q_full,
    output logic                 push,
    output r2d_pkg::r2d_op_t     op
);
    import r2d_pkg::*;

    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic [COUNT_W-1:0] count_reg  [0:MAX_DIMS];
    logic [COUNT_W-1:0] count_next [0:MAX_DIMS];
    logic [DEPTH_W-1:0] cur_depth;
    logic [DEPTH_W-1:0] depth_dec;
    logic [COUNT_W-1:0] cur_count;
    logic [COUNT_W-1:0] length;
    logic [OFFSET_W-1:0] stride_sel;
    token_kind_t        kind;
    logic               start;
    logic               accept;

    assign kind     = token_kind_t'(s_tuser[1:0]);
    assign start    = s_tuser[2];
    assign s_tready = !cfg.busy && !q_full;
    assign accept   = s_tvalid && s_tready;

    // A record start clears the tracking state before the token applies.
    assign cur_depth = start ? '0 : depth_reg;
    assign cur_count = start ? '0 : count_reg[depth_reg];
    assign depth_dec = cur_depth - DEPTH_W'(1);
    assign length    = cfg.dim_len[depth_dec[SIZE_IDX_W-1:0]];

    always_comb begin
        if (cur_depth != '0) begin
            stride_sel = cfg.stride[cur_depth];
        end else begin
            stride_sel = 32'd1;
        end
    end

    // Next depth and counts.
    always_comb begin
        depth_next = cur_depth;
        for (int i = 0; i <= MAX_DIMS; i++) begin
            count_next[i] = start ? '0 : count_reg[i];
        end
        unique case (kind)
            TOK_BEGIN: begin
                if (cur_depth < cfg.eff_dims) begin
                    if (cur_count != {COUNT_W{1'b1}}) begin
                        count_next[cur_depth] = cur_count + COUNT_W'(1);
                    end
                    depth_next = cur_depth + DEPTH_W'(1);
                end
            end
            TOK_COUNT: begin
                count_next[cur_depth] = s_tdata;
            end
            TOK_FINISH: begin
                if (cur_depth != '0) begin
                    count_next[cur_depth] = '0;
                    depth_next            = depth_dec;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            count_reg <= '{default: '0};
        end else if (accept) begin
            depth_reg <= depth_next;
            count_reg <= count_next;
        end
    end

    // Classified operation for the back. Clears travel even without a result.
    assign push         = accept && (start || kind == TOK_FINISH);
    assign op.clr       = start;
    assign op.emit      = (kind == TOK_FINISH);
    assign op.act       = (cur_depth != '0);
    assign op.inner     = (cur_depth == cfg.eff_dims);
    assign op.over      = (cur_count > length);
    assign op.under     = (cur_count < length);
    assign op.count     = cur_count;
    assign op.length    = length;
    assign op.shortfall = length - cur_count;
    assign op.stride    = stride_sel;

endmodule

// File: rtl/core/r2d_queue.sv
// ----------------------------------------------------------------------------
// r2d_queue
// Short first-in first-out queue of classified operations between the front
// and the back.
// ----------------------------------------------------------------------------
module r2d_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  r2d_pkg::r2d_op_t  push_op,
    output logic              q_full,
    input  logic              pop,
    output logic              q_valid,
    output r2d_pkg::r2d_op_t  head_op
);
    import r2d_pkg::*;

    r2d_op_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QCNT_W-1:0]   cnt_next;

    assign q_full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign head_op = entry_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    // The front must never push into a full queue.
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !push)
        else $error("r2d_queue: push while full");

endmodule

// File: rtl/core/r2d_back.sv
// ----------------------------------------------------------------------------
// r2d_back
// Carries out queued operations: keeps the dense offset and the sticky error,
// works out copy and fill ranges, and holds the result word for the output.
// ----------------------------------------------------------------------------
module r2d_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  r2d_pkg::r2d_op_t  head_op,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [111:0]      m_tdata,  // [31:0] copy_offset, [47:32] copy_length,
                                        // [79:48] fill_offset, [111:80] fill_length
    output logic [2:0]        m_tuser   // [0] copy_valid, [1] fill_valid,
                                        // [2] overflow_error
);
    import r2d_pkg::*;

    logic [OFFSET_W-1:0]          offset_reg;
    logic [OFFSET_W-1:0]          offset_next;
    logic                         err_reg;
    logic                         err_next;
    logic                         m_tvalid_reg;
    logic                         m_tvalid_next;
    logic [111:0]                 tdata_reg;
    logic [2:0]                   tuser_reg;
    logic [OFFSET_W-1:0]          off0;
    logic                         err0;
    logic [COUNT_W+OFFSET_W-1:0]  prod;
    logic                         cv;
    logic                         fv;
    logic [OFFSET_W-1:0]          co;
    logic [COUNT_W-1:0]           cl;
    logic [OFFSET_W-1:0]          fo;
    logic [OFFSET_W-1:0]          fl;
    logic                         out_free;
    logic                         load;

    assign out_free = !m_tvalid_reg || m_tready;
    assign pop      = q_valid && (!head_op.emit || out_free);
    assign load     = pop && head_op.emit;

    // A record start clears offset and error before the operation.
    assign off0 = head_op.clr ? '0 : offset_reg;
    assign err0 = head_op.clr ? 1'b0 : err_reg;
    assign prod = head_op.stride * head_op.shortfall;

    // Range generation and state update.
    always_comb begin
        offset_next = off0;
        err_next    = err0;
        cv = 1'b0;
        fv = 1'b0;
        co = '0;
        cl = '0;
        fo = '0;
        fl = '0;
        if (head_op.emit && head_op.act) begin
            if (head_op.inner) begin
                if (head_op.over) begin
                    err_next = 1'b1;
                end else if (!err0) begin
                    if (head_op.count != '0) begin
                        cv = 1'b1;
                        co = off0;
                        cl = head_op.count;
                    end
                    if (head_op.under) begin
                        fv = 1'b1;
                        fo = off0 + OFFSET_W'(head_op.count);
                        fl = OFFSET_W'(head_op.shortfall);
                    end
                end
                offset_next = off0 + OFFSET_W'(head_op.length);
            end else if (head_op.under) begin
                if (!err0) begin
                    fv = 1'b1;
                    fo = off0;
                    fl = prod[OFFSET_W-1:0];
                end
                offset_next = off0 + prod[OFFSET_W-1:0];
            end
        end
    end

    // Output word valid flag.
    always_comb begin
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg   <= '0;
            err_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (pop) begin
                offset_reg <= offset_next;
                err_reg    <= err_next;
            end
        end
    end

    // Result word.
    always_ff @(posedge aclk) begin
        if (load) begin
            tdata_reg <= {fl, fo, cl, co};
            tuser_reg <= {err_next, fv, cv};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

    // A range is never given together with the error flag.
    a_range_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (tuser_reg[0] || tuser_reg[1]) |-> !tuser_reg[2])
        else $error("r2d_back: range given with error set");

    // At the innermost level the padding starts right after the copy.
    a_fill_after_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && tuser_reg[0] && tuser_reg[1] |->
            tdata_reg[79:48] == (tdata_reg[31:0] + {16'd0, tdata_reg[47:32]}))
        else $error("r2d_back: fill range does not follow copy range");

    // The error stays set until a record start clears it.
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg && !(pop && head_op.clr) |=> err_reg)
        else $error("r2d_back: error flag dropped without record start");

endmodule

// File: rtl/core/ragged_to_dense_copy_fill_ranges_core.sv
// ----------------------------------------------------------------------------
// ragged_to_dense_copy_fill_ranges_core
// Turns a stream of nesting tokens into dense copy and fill ranges.
//
//   Channel  Dir  Handshake            Word
//   s_       in   s_tvalid/s_tready    tdata element_total; tuser kind, start
//   m_       out  m_tvalid/m_tready    tdata offsets, lengths; tuser flags
//   apb      in   psel/penable/pready  dim_count, four dimension sizes
//
// One token is accepted per cycle while the queue has room and the stride
// sequencer is idle; a result is registered in the queue, then in the result
// word. A four-word queue between front and back lets input keep flowing while
// a result waits on m_tready. A register write reruns the stride sequencer,
// one multiply per level, holding s_tready low. Reset is synchronous and
// clears depth, counts, offset, error and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ragged_to_dense_copy_fill_ranges_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input token stream.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,   // [15:0] element_total
    input  logic [2:0]                   s_tuser,   // [1:0] token_kind, [2] record_start
    // Result stream.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [111:0]                 m_tdata,   // [31:0] copy_offset,
                                                    // [47:32] copy_length,
                                                    // [79:48] fill_offset,
                                                    // [111:80] fill_length
    output logic [2:0]                   m_tuser,   // [0] copy_valid, [1] fill_valid,
                                                    // [2] overflow_error
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [r2d_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import r2d_pkg::*;

    r2d_cfg_t cfg;
    r2d_op_t  push_op;
    r2d_op_t  head_op;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_valid;

    // Registers and strides.
    r2d_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Token front.
    r2d_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .op       (push_op)
    );

    // Operation queue.
    r2d_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .q_full  (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .head_op (head_op)
    );

    // Range back.
    r2d_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .head_op  (head_op),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ragged-to-dense copy/fill range core.
//
// Nesting tokens are sent on the s_ stream and the bench keeps its own copy
// of depth, level counts, dense offset, strides and the sticky error. Each
// accepted finish word queues the copy and fill ranges it should produce, and
// every word taken from the m_ stream is checked field by field against the
// oldest entry. A directed part covers the register port, the field extremes
// and the corner cases of the token handling. Random records of random shape
// follow, under three patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import r2d_pkg::*;

    localparam logic [1:0] TOK_UNUSED   = 2'd3;
    localparam int CYCLE_LIMIT          = 400000;
    localparam int SETTLE_CYCLES        = 8;
    localparam int TOKENS_PER_PHASE     = 330;
    localparam int TOKENS_PER_SHAPE     = 80;

    // One expected result word.
    typedef struct packed {
        logic        copy_valid;
        logic [31:0] copy_offset;
        logic [15:0] copy_length;
        logic        fill_valid;
        logic [31:0] fill_offset;
        logic [31:0] fill_length;
        logic        overflow_error;
    } range_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;    // [15:0] element_total
    logic [2:0]           s_tuser = '0;    // [1:0] token_kind, [2] record_start
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [111:0]         m_tdata;         // [31:0] copy_offset, [47:32] copy_length,
                                           // [79:48] fill_offset, [111:80] fill_length
    logic [2:0]           m_tuser;         // [0] copy_valid, [1] fill_valid,
                                           // [2] overflow_error
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Shadow copy of the configuration and the record state.
    logic [2:0]           dim_cfg = 3'd1;
    logic [15:0]          shape_len [REG_DIMS] = '{default: 16'd1};
    logic [31:0]          level_stride [MAX_DIMS+1] = '{default: 32'd1};
    int                   nest_level = 0;
    logic [15:0]          group_count [MAX_DIMS+1] = '{default: 16'd0};
    logic [31:0]          dense_pos = '0;
    bit                   error_flag = 1'b0;

    range_result_t        pending_ranges [$];
    int                   mismatch_count = 0;
    int                   token_total = 0;
    int                   cycle_count = 0;
    int                   send_gap_pct = 0;
    int                   recv_idle_pct = 0;

    ragged_to_dense_copy_fill_ranges_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Give up on a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The receiver stalls at random with the current idle rate.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Dimension count as the core uses it: 0 acts as 1, large values clip.
    function automatic int active_dims();
        int n;
        n = dim_cfg;
        if (n < 1) n = 1;
        if (n > DIM_LIMIT) n = DIM_LIMIT;
        return n;
    endfunction

    // Apply one token to the shadow state. A finish word queues its ranges.
    // Returns 1 when the token had an effect on the record.
    function automatic bit advance_ranges(logic [1:0] kind, logic [15:0] total, logic start);
        int n;
        int d;
        logic [15:0] cnt;
        logic [15:0] len;
        logic [31:0] delta;
        range_result_t r;
        n = active_dims();
        r = '0;
        if (start) begin
            nest_level = 0;
            group_count = '{default: 16'd0};
            dense_pos = '0;
            error_flag = 1'b0;
        end
        case (kind)
            TOK_BEGIN: begin
                // A begin past the innermost level is dropped.
                if (nest_level >= n) return 1'b0;
                if (group_count[nest_level] != 16'hFFFF)
                    group_count[nest_level] = group_count[nest_level] + 16'd1;
                nest_level++;
                return 1'b1;
            end
            TOK_COUNT: begin
                group_count[nest_level] = total;
                return 1'b1;
            end
            TOK_FINISH: begin
                if (nest_level > 0) begin
                    d = nest_level;
                    cnt = group_count[d];
                    len = shape_len[d-1];
                    if (d == n) begin
                        // Innermost group: copy what is there, pad the rest.
                        if (cnt > len) begin
                            error_flag = 1'b1;
                        end else if (!error_flag) begin
                            if (cnt > 0) begin
                                r.copy_valid  = 1'b1;
                                r.copy_offset = dense_pos;
                                r.copy_length = cnt;
                            end
                            if (cnt < len) begin
                                r.fill_valid  = 1'b1;
                                r.fill_offset = dense_pos + cnt;
                                r.fill_length = 32'(len - cnt);
                            end
                        end
                        dense_pos = dense_pos + len;
                    end else if (cnt < len) begin
                        // Outer group: skip the missing sub-blocks.
                        delta = level_stride[d] * 32'(len - cnt);
                        if (!error_flag) begin
                            r.fill_valid  = 1'b1;
                            r.fill_offset = dense_pos;
                            r.fill_length = delta;
                        end
                        dense_pos = dense_pos + delta;
                    end
                    group_count[d] = '0;
                    nest_level = d - 1;
                end
                r.overflow_error = error_flag;
                pending_ranges = {pending_ranges, r};
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // One register access on the configuration port. Writes also update the
    // shadow configuration and recompute the strides. The bus returns to idle
    // after each access.
    task automatic reg_access(logic write_en, reg_index_t idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        int n;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(negedge aclk); while (!pready);
        rdata = prdata;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (write_en) begin
            if (idx == REG_DIM_COUNT) dim_cfg = wdata[2:0];
            else shape_len[int'(idx) - int'(REG_DIM_SIZE0)] = wdata[15:0];
            n = active_dims();
            level_stride = '{default: 32'd1};
            for (int i = n; i > 0; i--) level_stride[i-1] = shape_len[i-1] * level_stride[i];
        end
        @(posedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        logic [31:0] unused_rdata;
        reg_access(1'b1, idx, value, unused_rdata);
    endtask

    // Send one token word, idling first at the current sender rate.
    task automatic send_token(logic [1:0] kind, logic [15:0] total, logic start);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= total;
        s_tuser  <= {start, kind};
        do @(negedge aclk); while (!s_tready);
        if (advance_ranges(kind, total, start)) token_total++;
        @(posedge aclk);
    endtask

    // Stop sending until every queued result has come back, then let the
    // pipeline settle so that a register write finds the core idle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_ranges.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Compare one field of a result word.
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Each result word taken by the receiver is matched with the oldest entry.
    always @(negedge aclk) begin : result_check
        range_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_ranges.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                         $time, m_tdata, m_tuser);
            end else begin
                want = pending_ranges.pop_front();
                check_field("copy_valid", 32'(want.copy_valid), 32'(m_tuser[0]));
                check_field("copy_offset", want.copy_offset, m_tdata[31:0]);
                check_field("copy_length", 32'(want.copy_length), 32'(m_tdata[47:32]));
                check_field("fill_valid", 32'(want.fill_valid), 32'(m_tuser[1]));
                check_field("fill_offset", want.fill_offset, m_tdata[79:48]);
                check_field("fill_length", want.fill_length, m_tdata[111:80]);
                check_field("overflow_error", 32'(want.overflow_error), 32'(m_tuser[2]));
            end
        end
    end

    // Write every register with junk in the unused bits, then read all back.
    task automatic test_register_access();
        logic [31:0] got;
        logic [31:0] want;
        write_reg(REG_DIM_COUNT, 32'hFFFF_FFFA);
        write_reg(REG_DIM_SIZE0, 32'hA5A5_0003);
        write_reg(REG_DIM_SIZE1, 32'h5A5A_0004);
        write_reg(REG_DIM_SIZE2, 32'hFFFF_0000);
        write_reg(REG_DIM_SIZE3, 32'h0001_FFFF);
        for (int i = 0; i <= int'(REG_DIM_SIZE3); i++) begin
            reg_access(1'b0, reg_index_t'(i), 32'hDEAD_BEEF, got);
            want = (i == int'(REG_DIM_COUNT)) ? 32'(dim_cfg) : 32'(shape_len[i-1]);
            if (got !== want) begin
                mismatch_count++;
                $display("%0t: register %0d readback, expected %0h, actual %0h",
                         $time, i, want, got);
            end
        end
    endtask

    // Two levels of 3 x 4: saturation, too-deep begin, overflow and the
    // sticky error, finish with nothing open, the unused token code.
    task automatic test_token_cases();
        send_token(TOK_BEGIN, 16'h0000, 1'b1);
        send_token(TOK_COUNT, 16'hFFFF, 1'b0);
        send_token(TOK_BEGIN, 16'hFFFF, 1'b0);     // group count stays saturated
        send_token(TOK_COUNT, 16'd4, 1'b0);        // copy only, no padding
        send_token(TOK_FINISH, 16'h0000, 1'b0);
        send_token(TOK_FINISH, 16'h0000, 1'b0);    // more groups than the size
        send_token(TOK_BEGIN, 16'h0000, 1'b1);
        send_token(TOK_BEGIN, 16'h0000, 1'b0);
        send_token(TOK_BEGIN, 16'h0000, 1'b0);     // past the innermost level
        send_token(TOK_COUNT, 16'd0, 1'b0);        // padding only
        send_token(TOK_FINISH, 16'h0000, 1'b0);
        send_token(TOK_BEGIN, 16'h0000, 1'b0);
        send_token(TOK_COUNT, 16'd5, 1'b0);        // one more than the size
        send_token(TOK_FINISH, 16'h0000, 1'b0);
        send_token(TOK_FINISH, 16'h0000, 1'b0);    // error holds back the fill
        send_token(TOK_FINISH, 16'h0000, 1'b0);    // nothing open
        send_token(TOK_UNUSED, 16'hFFFF, 1'b1);    // ignored, but the start bit clears
        send_token(TOK_FINISH, 16'h0000, 1'b0);
        send_token(TOK_BEGIN, 16'h0000, 1'b0);
        send_token(TOK_FINISH, 16'h0000, 1'b0);    // whole outer group missing
    endtask

    // Dimension count below and above its range, largest sizes and wrap of
    // the strides and offsets.
    task automatic test_dim_extremes();
        drain_results();
        write_reg(REG_DIM_COUNT, 32'd0);
        write_reg(REG_DIM_SIZE0, 32'h0000_FFFF);
        send_token(TOK_BEGIN, 16'h0000, 1'b1);
        send_token(TOK_COUNT, 16'hFFFF, 1'b0);
        send_token(TOK_FINISH, 16'h0000, 1'b0);
        send_token(TOK_BEGIN, 16'h0000, 1'b0);
        send_token(TOK_FINISH, 16'h0000, 1'b0);
        drain_results();
        write_reg(REG_DIM_COUNT, 32'd7);
        write_reg(REG_DIM_SIZE1, 32'h0000_FFFF);
        write_reg(REG_DIM_SIZE2, 32'h0000_FFFF);
        send_token(TOK_BEGIN, 16'h0000, 1'b1);
        send_token(TOK_FINISH, 16'h0000, 1'b0);
        send_token(TOK_BEGIN, 16'h0000, 1'b0);
        send_token(TOK_FINISH, 16'h0000, 1'b0);
    endtask

    // Lower the dimension count while three levels are open: the deeper
    // finishes are handled as outer levels.
    task automatic test_depth_shrink();
        drain_results();
        write_reg(REG_DIM_COUNT, 32'd3);
        write_reg(REG_DIM_SIZE0, 32'd2);
        write_reg(REG_DIM_SIZE1, 32'd2);
        write_reg(REG_DIM_SIZE2, 32'd2);
        send_token(TOK_BEGIN, 16'h0000, 1'b1);
        send_token(TOK_BEGIN, 16'h0000, 1'b0);
        send_token(TOK_BEGIN, 16'h0000, 1'b0);
        send_token(TOK_COUNT, 16'd1, 1'b0);
        drain_results();
        write_reg(REG_DIM_COUNT, 32'd1);
        repeat (4) send_token(TOK_FINISH, 16'h0000, 1'b0);
    endtask

    // Element count for an innermost group: mostly in range, sometimes just
    // over, sometimes any 16-bit value.
    function automatic logic [15:0] pick_count(logic [15:0] len);
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return len + 16'd1;
            2: return len;
            3: return 16'd0;
            default: return 16'($urandom_range(0, int'(len)));
        endcase
    endfunction

    // Number of subgroups for an outer level, around its size.
    function automatic int pick_groups(int lvl);
        int len;
        len = shape_len[lvl-1];
        return $urandom_range(0, (len < 4) ? len + 1 : 4);
    endfunction

    // Random shape: count across its whole 3-bit range, small outer sizes,
    // and an innermost size that is now and then large.
    task automatic load_random_shape();
        int n;
        logic [15:0] len;
        write_reg(REG_DIM_COUNT, {29'($urandom), 3'($urandom_range(0, 7))});
        n = active_dims();
        for (int i = 0; i < REG_DIMS; i++) begin
            if (i == n - 1) len = ($urandom_range(5) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 5));
            else len = 16'($urandom_range(0, 3));
            write_reg(reg_index_t'(int'(REG_DIM_SIZE0) + i), {16'($urandom), len});
        end
    endtask

    // One well-formed record with random content, built level by level.
    task automatic send_record(logic start);
        int n;
        int lvl;
        int groups_left [MAX_DIMS+2];
        n = active_dims();
        lvl = 1;
        send_token(TOK_BEGIN, 16'($urandom), start);
        if (lvl < n) groups_left[lvl] = pick_groups(lvl);
        while (lvl > 0) begin
            if (lvl < n && groups_left[lvl] > 0) begin
                groups_left[lvl]--;
                send_token(TOK_BEGIN, 16'($urandom), 1'b0);
                lvl++;
                if (lvl < n) groups_left[lvl] = pick_groups(lvl);
            end else begin
                if (lvl == n && $urandom_range(9) != 0)
                    send_token(TOK_COUNT, pick_count(shape_len[lvl-1]), 1'b0);
                else if (lvl < n && $urandom_range(19) == 0)
                    send_token(TOK_COUNT, 16'($urandom_range(0, 5)), 1'b0);
                send_token(TOK_FINISH, 16'($urandom), 1'b0);
                lvl--;
            end
        end
    endtask

    // Random records mixed with stray tokens. The stream stops and drains
    // before each new shape is loaded.
    task automatic test_random_stream(int sender_pct, int receiver_pct);
        int first;
        int reshape_at;
        send_gap_pct  = sender_pct;
        recv_idle_pct = receiver_pct;
        first = token_total;
        reshape_at = token_total;
        while (token_total - first < TOKENS_PER_PHASE) begin
            if (token_total >= reshape_at) begin
                drain_results();
                load_random_shape();
                reshape_at = token_total + TOKENS_PER_SHAPE;
            end
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_token(2'($urandom_range(0, 3)), 16'($urandom), $urandom_range(7) == 0);
            end else begin
                send_record($urandom_range(5) != 0);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_gap_pct  = 20;
        recv_idle_pct = 20;
        test_register_access();
        test_token_cases();
        test_dim_extremes();
        test_depth_shrink();
        test_random_stream(34, 76);
        test_random_stream(76, 34);
        test_random_stream(0, 0);
        drain_results();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/r2d_pkg.sv
rtl/core/r2d_cfg.sv
rtl/core/r2d_front.sv
rtl/core/r2d_queue.sv
rtl/core/r2d_back.sv
rtl/core/ragged_to_dense_copy_fill_ranges_core.sv
bench/tb_top.sv
